/* design/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define R2Q_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Condition must hold at every clock edge out of reset.
`define R2Q_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invariant check failed");

`endif

/* design/r2q_pkg.sv */
// ----------------------------------------------------------------------------
// r2q_pkg
// Types and constants of the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package r2q_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 14;

	// clipped radicand, square root input and result
	localparam int RAD_W    = DATA_WIDTH + 2;
	localparam int SQ_IN_W  = ((RAD_W + FRAC_BITS + 1) / 2) * 2;
	localparam int ROOT_W   = SQ_IN_W / 2;
	localparam int SQ_REM_W = ROOT_W + 3;

	// numerator magnitude, divider remainder and quotient
	localparam int MAG_W     = DATA_WIDTH + 1;
	localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
	localparam int DIVS_W    = ROOT_W + 1 + DATA_WIDTH;
	localparam int DIV_REM_W = ((NUM_W > DIVS_W) ? NUM_W : DIVS_W) + 1;
	localparam int QUO_W     = DATA_WIDTH + 1;

	localparam int STAGES = 2 + ROOT_W + QUO_W;
	localparam int CNT_W  = $clog2(STAGES + 1);

	localparam logic [1:0] LANE_X = 2'd0;
	localparam logic [1:0] LANE_Y = 2'd1;
	localparam logic [1:0] LANE_Z = 2'd2;
	localparam logic [1:0] LANE_W = 2'd3;

	typedef logic signed [DATA_WIDTH-1:0] elem_t;

	typedef struct packed {
		elem_t m_c0r0;
		elem_t m_c0r1;
		elem_t m_c0r2;
		elem_t m_c1r0;
		elem_t m_c1r1;
		elem_t m_c1r2;
		elem_t m_c2r0;
		elem_t m_c2r1;
		elem_t m_c2r2;
	} matrix_t;

	typedef struct packed {
		elem_t quat_x;
		elem_t quat_y;
		elem_t quat_z;
		elem_t quat_w;
	} quat_t;

	// item state carried from cell to cell
	typedef struct packed {
		logic [1:0]                  root_idx;
		logic [SQ_IN_W-1:0]          sq_in;
		logic [SQ_REM_W-1:0]         sq_rem;
		logic [ROOT_W-1:0]           root;
		logic [3:0]                  neg;
		logic [3:0][MAG_W-1:0]       mag;
		logic [DIV_REM_W-1:0]        dsh;
		logic [3:0][DIV_REM_W-1:0]   rem;
		logic [3:0][QUO_W-1:0]       quo;
	} work_t;

endpackage

`default_nettype wire

/* design/r2q_front.sv */
// ----------------------------------------------------------------------------
// r2q_front
// Trace, axis choice, radicand and numerators; first pipeline register.
// ----------------------------------------------------------------------------
`default_nettype none

module r2q_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_vld,
	output logic                 in_rdy,
	input  wire r2q_pkg::matrix_t in_mat,
	output logic                 out_vld,
	input  wire logic            out_rdy,
	output r2q_pkg::work_t       out_w
);

	localparam int EW = r2q_pkg::DATA_WIDTH + 3;
	localparam int NW = r2q_pkg::DATA_WIDTH + 2;

	logic signed [EW-1:0] e [9];
	logic signed [EW-1:0] trace, rad, one, diag_i;
	logic signed [NW-1:0] num [4];
	logic [1:0]           axis;
	logic                 pos_trace;
	r2q_pkg::work_t       w_d, w_s1;
	logic                 vld_s1;

	always_comb begin
		e[0] = EW'(in_mat.m_c0r0);
		e[1] = EW'(in_mat.m_c0r1);
		e[2] = EW'(in_mat.m_c0r2);
		e[3] = EW'(in_mat.m_c1r0);
		e[4] = EW'(in_mat.m_c1r1);
		e[5] = EW'(in_mat.m_c1r2);
		e[6] = EW'(in_mat.m_c2r0);
		e[7] = EW'(in_mat.m_c2r1);
		e[8] = EW'(in_mat.m_c2r2);
		one = EW'(1) <<< r2q_pkg::FRAC_BITS;
		trace = e[0] + e[4] + e[8];
		pos_trace = trace > 0;

		// strict compares keep the lower index on ties
		axis = (e[4] > e[0]) ? r2q_pkg::LANE_Y : r2q_pkg::LANE_X;
		diag_i = (axis == r2q_pkg::LANE_Y) ? e[4] : e[0];
		if (e[8] > diag_i)
			axis = r2q_pkg::LANE_Z;

		for (int p = 0; p < 4; p++)
			num[p] = '0;
		if (pos_trace) begin
			rad = trace + one;
			num[0] = NW'(e[5] - e[7]);
			num[1] = NW'(e[6] - e[2]);
			num[2] = NW'(e[1] - e[3]);
		end else begin
			case (axis)
				r2q_pkg::LANE_Y: begin
					rad = e[4] - e[8] - e[0] + one;
					num[3] = NW'(e[6] - e[2]);
					num[2] = NW'(e[5] + e[7]);
					num[0] = NW'(e[3] + e[1]);
				end
				r2q_pkg::LANE_Z: begin
					rad = e[8] - e[0] - e[4] + one;
					num[3] = NW'(e[1] - e[3]);
					num[0] = NW'(e[6] + e[2]);
					num[1] = NW'(e[7] + e[5]);
				end
				default: begin
					rad = e[0] - e[4] - e[8] + one;
					num[3] = NW'(e[5] - e[7]);
					num[1] = NW'(e[1] + e[3]);
					num[2] = NW'(e[2] + e[6]);
				end
			endcase
		end

		w_d = '0;
		w_d.root_idx = pos_trace ? r2q_pkg::LANE_W : axis;
		// a radicand below zero counts as zero
		w_d.sq_in = (rad > 0) ?
			(r2q_pkg::SQ_IN_W'(rad[r2q_pkg::RAD_W-1:0]) << r2q_pkg::FRAC_BITS) : '0;
		for (int p = 0; p < 4; p++) begin
			w_d.neg[p] = num[p][NW-1];
			w_d.mag[p] = num[p][NW-1] ? r2q_pkg::MAG_W'(-num[p]) : r2q_pkg::MAG_W'(num[p]);
		end
	end

	assign in_rdy = !vld_s1 || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_rdy)
			vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (in_vld && in_rdy)
			w_s1 <= w_d;
	end

	assign out_vld = vld_s1;
	assign out_w   = w_s1;

endmodule

`default_nettype wire

/* design/r2q_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// r2q_sqrt_cell
// One root bit of the digit-by-digit square root per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module r2q_sqrt_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_vld,
	output logic                in_rdy,
	input  wire r2q_pkg::work_t in_w,
	output logic                out_vld,
	input  wire logic           out_rdy,
	output r2q_pkg::work_t      out_w
);

	logic [r2q_pkg::SQ_REM_W-1:0] rem_sh, trial;
	r2q_pkg::work_t               w_d, w_q;
	logic                         vld_q;

	always_comb begin
		w_d = in_w;
		rem_sh = {in_w.sq_rem[r2q_pkg::SQ_REM_W-3:0], in_w.sq_in[r2q_pkg::SQ_IN_W-1 -: 2]};
		trial = {1'b0, in_w.root, 2'b01};
		if (rem_sh >= trial) begin
			w_d.sq_rem = rem_sh - trial;
			w_d.root = {in_w.root[r2q_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			w_d.sq_rem = rem_sh;
			w_d.root = {in_w.root[r2q_pkg::ROOT_W-2:0], 1'b0};
		end
		w_d.sq_in = {in_w.sq_in[r2q_pkg::SQ_IN_W-3:0], 2'b00};
	end

	assign in_rdy = !vld_q || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (in_rdy)
			vld_q <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (in_vld && in_rdy)
			w_q <= w_d;
	end

	assign out_vld = vld_q;
	assign out_w   = w_q;

endmodule

`default_nettype wire

/* design/r2q_div_cell.sv */
// ----------------------------------------------------------------------------
// r2q_div_cell
// One quotient bit of the restoring divide per cell, four lanes wide.
// ----------------------------------------------------------------------------
`default_nettype none

module r2q_div_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_vld,
	output logic                in_rdy,
	input  wire r2q_pkg::work_t in_w,
	output logic                out_vld,
	input  wire logic           out_rdy,
	output r2q_pkg::work_t      out_w
);

	r2q_pkg::work_t w_d, w_q;
	logic           vld_q;
	logic           ge;

	always_comb begin
		w_d = in_w;
		ge = 1'b0;
		for (int p = 0; p < 4; p++) begin
			ge = in_w.rem[p] >= in_w.dsh;
			if (ge)
				w_d.rem[p] = in_w.rem[p] - in_w.dsh;
			w_d.quo[p] = {in_w.quo[p][r2q_pkg::QUO_W-2:0], ge};
		end
		// advance the divisor one bit down
		w_d.dsh = in_w.dsh >> 1;
	end

	assign in_rdy = !vld_q || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (in_rdy)
			vld_q <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (in_vld && in_rdy)
			w_q <= w_d;
	end

	assign out_vld = vld_q;
	assign out_w   = w_q;

endmodule

`default_nettype wire

/* design/r2q_out.sv */
// ----------------------------------------------------------------------------
// r2q_out
// Half root, sign and saturation per component; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module r2q_out (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_vld,
	output logic                in_rdy,
	input  wire r2q_pkg::work_t in_w,
	output logic                out_vld,
	input  wire logic           out_rdy,
	output r2q_pkg::quat_t      out_q
);

	localparam int DW = r2q_pkg::DATA_WIDTH;
	localparam logic [r2q_pkg::QUO_W-1:0] HI_Q  = r2q_pkg::QUO_W'((1 << (DW - 1)) - 1);
	localparam logic [r2q_pkg::QUO_W-1:0] MAG_LO = r2q_pkg::QUO_W'(1) << (DW - 1);

	logic [r2q_pkg::ROOT_W:0]  half;
	logic [DW-1:0]             half_sat;
	logic [3:0][DW-1:0]        lane;
	logic [r2q_pkg::QUO_W-1:0] q;
	r2q_pkg::quat_t            q_d, q_q;
	logic                      vld_q;

	always_comb begin
		half = ((r2q_pkg::ROOT_W + 1)'(in_w.root) + 1'b1) >> 1;
		half_sat = (half > (r2q_pkg::ROOT_W + 1)'(HI_Q)) ? DW'(HI_Q) : DW'(half);
		q = '0;
		for (int p = 0; p < 4; p++) begin
			q = in_w.quo[p];
			if (in_w.root_idx == 2'(p))
				lane[p] = half_sat;
			else if (in_w.root == '0)
				lane[p] = '0;
			else if (!in_w.neg[p])
				lane[p] = (q > HI_Q) ? DW'(HI_Q) : DW'(q);
			else
				lane[p] = (q > MAG_LO) ? DW'(MAG_LO) : DW'(-q);
		end
		q_d.quat_x = lane[r2q_pkg::LANE_X];
		q_d.quat_y = lane[r2q_pkg::LANE_Y];
		q_d.quat_z = lane[r2q_pkg::LANE_Z];
		q_d.quat_w = lane[r2q_pkg::LANE_W];
	end

	assign in_rdy = !vld_q || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (in_rdy)
			vld_q <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (in_vld && in_rdy)
			q_q <= q_d;
	end

	assign out_vld = vld_q;
	assign out_q   = q_q;

endmodule

`default_nettype wire

/* design/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shoemake conversion of a Q1.14 rotation matrix into a Q1.14 quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   mat / mat_valid / mat_ready carry one 3x3 matrix per item, column-major.
//   quat / quat_valid / quat_ready return one quaternion (x, y, z, w) per item.
//   The datapath is a row of cells: a front stage (trace, axis, radicand),
//   16 square-root cells, one root bit each, 17 restoring divide cells, one
//   quotient bit each for four lanes, and an output register.
//   One item per cycle is taken and delivered in steady state while
//   quat_ready stays high.
//   Each cell holds its item until the next one can take it, so a stalled
//   receiver fills the row from the end and bubbles are squeezed out;
//   mat_ready drops only once every cell holds an item.
//   Reset empties the row at once; no items are lost or replayed afterwards.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rotation_matrix_to_quaternion (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             mat_valid,
	output logic                  mat_ready,
	input  wire r2q_pkg::matrix_t mat,
	output logic                  quat_valid,
	input  wire logic             quat_ready,
	output r2q_pkg::quat_t        quat
);

	localparam int NSQ  = r2q_pkg::ROOT_W;
	localparam int NDIV = r2q_pkg::QUO_W;
	localparam int CW   = r2q_pkg::CNT_W;

	logic           sq_vld [0:NSQ];
	logic           sq_rdy [0:NSQ];
	r2q_pkg::work_t sq_w   [0:NSQ];
	logic           dv_vld [0:NDIV];
	logic           dv_rdy [0:NDIV];
	r2q_pkg::work_t dv_w   [0:NDIV];
	logic [CW-1:0]  cnt_q;

	r2q_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (mat_valid),
		.in_rdy  (mat_ready),
		.in_mat  (mat),
		.out_vld (sq_vld[0]),
		.out_rdy (sq_rdy[0]),
		.out_w   (sq_w[0])
	);

	for (genvar g = 0; g < NSQ; g++) begin : g_sq
		r2q_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (sq_vld[g]),
			.in_rdy  (sq_rdy[g]),
			.in_w    (sq_w[g]),
			.out_vld (sq_vld[g+1]),
			.out_rdy (sq_rdy[g+1]),
			.out_w   (sq_w[g+1])
		);
	end

	// load dividends (n << F) + s and divisor 2s aligned to the overflow bit
	always_comb begin
		dv_w[0] = sq_w[NSQ];
		dv_w[0].dsh = r2q_pkg::DIV_REM_W'({sq_w[NSQ].root, 1'b0}) << r2q_pkg::DATA_WIDTH;
		for (int p = 0; p < 4; p++) begin
			dv_w[0].rem[p] = (r2q_pkg::DIV_REM_W'(sq_w[NSQ].mag[p]) << r2q_pkg::FRAC_BITS)
				+ r2q_pkg::DIV_REM_W'(sq_w[NSQ].root);
			dv_w[0].quo[p] = '0;
		end
	end
	assign dv_vld[0]   = sq_vld[NSQ];
	assign sq_rdy[NSQ] = dv_rdy[0];

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		r2q_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (dv_vld[g]),
			.in_rdy  (dv_rdy[g]),
			.in_w    (dv_w[g]),
			.out_vld (dv_vld[g+1]),
			.out_rdy (dv_rdy[g+1]),
			.out_w   (dv_w[g+1])
		);
	end

	r2q_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (dv_vld[NDIV]),
		.in_rdy  (dv_rdy[NDIV]),
		.in_w    (dv_w[NDIV]),
		.out_vld (quat_valid),
		.out_rdy (quat_ready),
		.out_q   (quat)
	);

	// items in flight, for the checks below
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else
			cnt_q <= cnt_q + CW'(mat_valid && mat_ready) - CW'(quat_valid && quat_ready);
	end

	`R2Q_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(r2q_pkg::STAGES))
	`R2Q_ASSERT_IMPLY(a_empty_no_out, cnt_q == '0, !quat_valid)
	`R2Q_ASSERT_IMPLY(a_stall_only_full, !mat_ready, quat_valid && !quat_ready)

endmodule

`default_nettype wire

/* sim/tb_rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// Self-checking bench: matrices are driven through the valid/ready input,
// quaternions are predicted in fixed point and compared field by field,
// with random sender gaps and receiver stalls over several phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rotation_matrix_to_quaternion;
	timeunit 1ns;
	timeprecision 1ps;

	import r2q_pkg::*;

	localparam int ONE      = 1 << FRAC_BITS;
	localparam int LAT      = 35;
	localparam int N_RANDOM = 1750;
	localparam longint LIMIT = 400000;

	// Shoemake predictor and queue of pending quaternions
	class quat_scoreboard;
		quat_t  pending[$];
		int     errors;
		int     checked;

		function longint sat16(longint v);
			longint hi;
			longint lo;
			hi = (longint'(1) << (DATA_WIDTH - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) return hi;
			if (v < lo) return lo;
			return v;
		endfunction

		function longint int_root(longint r);
			longint v;
			longint res;
			longint b;
			if (r <= 0) return 0;
			v = r << FRAC_BITS;
			res = 0;
			b = longint'(1) << 60;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		// n / (2 s), rounded to nearest with ties away from zero
		function longint div_by_root(longint n, longint s);
			longint mag;
			longint q;
			if (s == 0) return 0;
			mag = (n < 0) ? -n : n;
			q = ((mag << FRAC_BITS) + s) / (2 * s);
			return sat16((n < 0) ? -q : q);
		endfunction

		function void note_matrix(matrix_t m);
			longint v[9];
			longint q[4];
			longint tr;
			longint s;
			int     i;
			int     j;
			int     k;
			quat_t  r;
			v[0] = longint'(m.m_c0r0); v[1] = longint'(m.m_c0r1); v[2] = longint'(m.m_c0r2);
			v[3] = longint'(m.m_c1r0); v[4] = longint'(m.m_c1r1); v[5] = longint'(m.m_c1r2);
			v[6] = longint'(m.m_c2r0); v[7] = longint'(m.m_c2r1); v[8] = longint'(m.m_c2r2);
			tr = v[0] + v[4] + v[8];
			if (tr > 0) begin
				s = int_root(tr + ONE);
				q[3] = sat16((s + 1) >> 1);
				q[0] = div_by_root(v[5] - v[7], s);
				q[1] = div_by_root(v[6] - v[2], s);
				q[2] = div_by_root(v[1] - v[3], s);
			end else begin
				i = 0;
				if (v[4] > v[0]) i = 1;
				if (v[8] > v[4 * i]) i = 2;
				j = (i + 1) % 3;
				k = (j + 1) % 3;
				s = int_root(v[4 * i] - v[4 * j] - v[4 * k] + ONE);
				q[i] = sat16((s + 1) >> 1);
				q[3] = div_by_root(v[3 * j + k] - v[3 * k + j], s);
				q[j] = div_by_root(v[3 * i + j] + v[3 * j + i], s);
				q[k] = div_by_root(v[3 * i + k] + v[3 * k + i], s);
			end
			r.quat_x = q[0][DATA_WIDTH-1:0];
			r.quat_y = q[1][DATA_WIDTH-1:0];
			r.quat_z = q[2][DATA_WIDTH-1:0];
			r.quat_w = q[3][DATA_WIDTH-1:0];
			pending.push_back(r);
		endfunction

		function void check_quat(quat_t got);
			quat_t e;
			checked++;
			if (pending.size() == 0) begin
				$error("quaternion with no matrix pending: %h", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.quat_x !== e.quat_x) begin
				$error("quat_x expected %0d got %0d", e.quat_x, got.quat_x);
				errors++;
			end
			if (got.quat_y !== e.quat_y) begin
				$error("quat_y expected %0d got %0d", e.quat_y, got.quat_y);
				errors++;
			end
			if (got.quat_z !== e.quat_z) begin
				$error("quat_z expected %0d got %0d", e.quat_z, got.quat_z);
				errors++;
			end
			if (got.quat_w !== e.quat_w) begin
				$error("quat_w expected %0d got %0d", e.quat_w, got.quat_w);
				errors++;
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    mat_valid;
	logic    mat_ready;
	matrix_t mat;
	logic    quat_valid;
	logic    quat_ready;
	quat_t   quat;

	quat_scoreboard sb;
	int      send_idle_pct;
	int      stall_pct;
	longint  cycles;
	int      sent;

	rotation_matrix_to_quaternion dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.mat_valid (mat_valid),
		.mat_ready (mat_ready),
		.mat       (mat),
		.quat_valid(quat_valid),
		.quat_ready(quat_ready),
		.quat      (quat)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("tb_rotation_matrix_to_quaternion: errors");
				$finish;
			end
		end
	end

	// receiver: stall at random, check each accepted quaternion
	initial begin
		quat_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && quat_valid && quat_ready) sb.check_quat(quat);
			@(negedge clk);
			quat_ready = ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_matrix(matrix_t m);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		mat_valid = 1'b1;
		mat = m;
		do @(posedge clk); while (!mat_ready);
		sb.note_matrix(m);
		sent++;
		@(negedge clk);
		mat_valid = 1'b0;
	endtask

	function automatic elem_t rnd_elem();
		return elem_t'($urandom);
	endfunction

	// element near a rotation entry: mostly moderate, sometimes extreme
	function automatic elem_t near(int centre);
		int v;
		if ($urandom_range(9) == 0) return rnd_elem();
		v = centre + int'($urandom_range(600)) - 300;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return elem_t'(v);
	endfunction

	// rotation-like matrix from a random signed permutation, perturbed
	function automatic matrix_t rnd_rotation();
		int      g[9];
		int      p;
		int      c;
		matrix_t m;
		p = $urandom_range(2);
		for (int n = 0; n < 9; n++) g[n] = 0;
		for (c = 0; c < 3; c++) begin
			if ($urandom_range(2) == 0)
				g[3 * c + (c + p) % 3] = $urandom_range(1) ? ONE : -ONE;
			else begin
				g[3 * c + (c + p) % 3] = int'($urandom_range(2 * ONE)) - ONE;
				g[3 * c + (c + p + 1) % 3] = int'($urandom_range(2 * ONE)) - ONE;
			end
		end
		m.m_c0r0 = near(g[0]); m.m_c0r1 = near(g[1]); m.m_c0r2 = near(g[2]);
		m.m_c1r0 = near(g[3]); m.m_c1r1 = near(g[4]); m.m_c1r2 = near(g[5]);
		m.m_c2r0 = near(g[6]); m.m_c2r1 = near(g[7]); m.m_c2r2 = near(g[8]);
		return m;
	endfunction

	function automatic matrix_t diag(int a, int b, int c, int off);
		matrix_t m;
		m = '{default: elem_t'(off)};
		m.m_c0r0 = elem_t'(a);
		m.m_c1r1 = elem_t'(b);
		m.m_c2r2 = elem_t'(c);
		return m;
	endfunction

	task automatic directed();
		matrix_t m;
		send_matrix(diag(ONE, ONE, ONE, 0));           // identity
		send_matrix(diag(ONE, -ONE, -ONE, 0));         // x axis picked
		send_matrix(diag(-ONE, ONE, -ONE, 0));         // y axis picked
		send_matrix(diag(-ONE, -ONE, ONE, 0));         // z axis picked
		send_matrix(diag(0, 0, 0, 0));                 // zero trace, tie on diagonal
		send_matrix(diag(-ONE, -ONE, -ONE, 0));        // ties, all negative
		send_matrix(diag(5, 5, -10, 100));             // tie between first two
		send_matrix(diag(-32768, -32768, -32768, 0));  // most negative diagonal, x axis picked
		send_matrix(diag(-32768, -32768, -32768, 32767));
		send_matrix(diag(32767, 32767, 32767, 0));     // largest trace
		send_matrix(diag(32767, 32767, 32767, -32768));
		send_matrix('{default: elem_t'(32767)});
		send_matrix('{default: elem_t'(-32768)});
		send_matrix(diag(1, 0, 0, 32767));             // tiny trace, big offsets
		send_matrix(diag(0, 0, 0, -32768));
		m = diag(-ONE, -ONE, -ONE + 1, 0);             // z axis picked, large off-diagonals
		m.m_c0r2 = elem_t'(32767); m.m_c2r0 = elem_t'(32767);
		m.m_c1r2 = elem_t'(-32768); m.m_c2r1 = elem_t'(32767);
		send_matrix(m);
		m = diag(32767, -32768, -32768, 0);            // x with largest radicand
		m.m_c0r1 = elem_t'(-32768); m.m_c1r0 = elem_t'(32767);
		send_matrix(m);
		send_matrix('{default: elem_t'(16'h5555)});
		send_matrix('{default: elem_t'(16'hAAAA)});
	endtask

	task automatic wait_drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LAT + 5) @(posedge clk);
	endtask

	task automatic random_phase(int n, int idle, int stall);
		matrix_t m;
		send_idle_pct = idle;
		stall_pct = stall;
		for (int t = 0; t < n; t++) begin
			if ($urandom_range(9) < 8) m = rnd_rotation();
			else m = {rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(),
				rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem()};
			send_matrix(m);
			// a stretch with no idling or stalls inside each phase
			if (t % 100 == 50) begin
				send_idle_pct = 0;
				stall_pct = 0;
			end else if (t % 100 == 80) begin
				send_idle_pct = idle;
				stall_pct = stall;
			end
		end
	endtask

	initial begin
		sb = new();
		sent = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		mat_valid = 1'b0;
		mat = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed();
		random_phase(N_RANDOM / 4, 0, 0);
		random_phase(N_RANDOM / 4, 66, 0);
		random_phase(N_RANDOM / 4, 0, 66);
		random_phase(N_RANDOM / 4, 26, 26);
		wait_drain();

		$display("sent %0d matrices, checked %0d quaternions over four handshake phases",
			sent, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb_rotation_matrix_to_quaternion: clean");
		end else begin
			$display("%0d mismatches, %0d quaternions missing", sb.errors,
				sb.pending.size());
			$display("tb_rotation_matrix_to_quaternion: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
+incdir+design
design/r2q_pkg.sv
design/r2q_front.sv
design/r2q_sqrt_cell.sv
design/r2q_div_cell.sv
design/r2q_out.sv
design/rotation_matrix_to_quaternion.sv
sim/tb_rotation_matrix_to_quaternion.sv
